// ===== rtl/sample_playback_mixer_core_assert.svh =====
// Assertion macros used by the port-level checker of the sample playback mixer.
`ifndef SAMPLE_PLAYBACK_MIXER_CORE_ASSERT_SVH
`define SAMPLE_PLAYBACK_MIXER_CORE_ASSERT_SVH

// Clocked property with reset disable.
`define SPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must hold its value while the master side stalls.
`define SPM_ASSERT_HOLD(lbl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (m_axis_tvalid && !m_axis_tready) |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/spm_pkg.sv =====
// Package with types and constants of the sample playback mixer.
package spm_pkg;

    localparam int CHANNELS  = 4;
    localparam int PTR_W     = 34;
    localparam int ACC_W     = 21;
    localparam int LEN_W     = 16;
    localparam int STEP_W    = 20;
    localparam int VOL_W     = 7;
    localparam int OVS_W     = 4;
    localparam int PROD_W    = 15;
    localparam int OUT_W     = 15;
    localparam int IN_DATA_W = 120;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [2:0] {
        OP_TICK, OP_WRITE, OP_NOTE, OP_STEP, OP_VOLUME, OP_POSITION
    } op_t;

    typedef enum logic [1:0] {
        MODE_SILENT, MODE_PLAY, MODE_LOOP
    } mode_t;

    typedef enum logic [1:0] {
        EV_ZERO, EV_READ, EV_AGAIN, EV_DIV
    } ev_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EVAL, ST_MAC, ST_ACC, ST_DIVP, ST_DIVL_GO, ST_DIVL, ST_DIVR, ST_OUT
    } state_t;

    typedef struct packed {
        logic       clr_acc;
        logic [1:0] ch;
        logic       eval;
        logic       mac;
        logic       acc;
        logic       ptr_wb;
        logic       div_l_start;
        logic       div_r_start;
        logic       store_l;
        logic       store_r;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        ev_t              ev;
        logic             div_done;
        logic             out_full;
        logic [OVS_W-1:0] n;
    } status_t;

endpackage

// ===== rtl/spm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module spm_div #(
    parameter int DW = 21,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          active_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg;
    logic [VW:0]   shifted;
    logic          ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? VW'(shifted - {1'b0, dvs_reg}) : shifted[VW-1:0];
        quo_next = {quo_reg[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
            cnt_reg    <= CW'(DW);
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (active_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/spm_dp.sv =====
// Datapath of the sample playback mixer: sample memory, channel state, mixing and scaling.
module spm_dp #(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_accept,
    input  spm_pkg::op_t                       in_op,
    input  logic [1:0]                         in_channel,
    input  logic [15:0]                        in_address,
    input  logic [7:0]                         in_sample_byte,
    input  logic [spm_pkg::LEN_W-1:0]          in_oneshot_length,
    input  logic [spm_pkg::LEN_W-1:0]          in_loop_start,
    input  logic [spm_pkg::LEN_W-1:0]          in_loop_length,
    input  logic [spm_pkg::STEP_W-1:0]         in_step_increment,
    input  logic [spm_pkg::VOL_W-1:0]          in_volume,
    input  logic [15:0]                        in_position,
    input  logic                               cfg_wen,
    input  logic [spm_pkg::OVS_W-1:0]          cfg_wdata,
    input  spm_pkg::cmd_t                      cmd,
    output spm_pkg::status_t                   status,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [spm_pkg::OUT_W-1:0]          out_left,
    output logic [spm_pkg::OUT_W-1:0]          out_right
);

    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int IW     = spm_pkg::PTR_W - FRAC_BITS;
    localparam int DW     = (IW > spm_pkg::ACC_W) ? IW : spm_pkg::ACC_W;
    localparam int PW     = spm_pkg::PTR_W;
    localparam int CH     = spm_pkg::CHANNELS;

    logic [7:0] mem [SAMPLE_DEPTH];
    logic [7:0] rdata_reg;
    logic [ADDR_W-1:0] rd_addr;

    spm_pkg::mode_t              mode_reg  [CH];
    logic [PW-1:0]               ptr_reg   [CH];
    logic [spm_pkg::STEP_W-1:0]  step_reg  [CH];
    logic [spm_pkg::VOL_W-1:0]   vol_reg   [CH];
    logic [spm_pkg::LEN_W-1:0]   start_reg [CH];
    logic [spm_pkg::LEN_W-1:0]   len_reg   [CH];
    logic [spm_pkg::LEN_W-1:0]   lstart_reg[CH];
    logic [spm_pkg::LEN_W-1:0]   llen_reg  [CH];

    logic [spm_pkg::OVS_W-1:0]        ovs_reg;
    logic signed [spm_pkg::PROD_W-1:0] prod_reg;
    logic signed [spm_pkg::ACC_W-1:0]  accl_reg, accr_reg;
    logic                              out_valid_reg;
    logic [spm_pkg::OUT_W-1:0]         lres_reg, rres_reg;
    logic [spm_pkg::OUT_W-1:0]         left_reg, right_reg;

    logic [1:0]      c;
    logic [PW-1:0]   ptr, lenx;
    logic [IW-1:0]   intp;
    spm_pkg::ev_t    ev;
    logic [spm_pkg::LEN_W-1:0] base;
    logic [spm_pkg::LEN_W-1:0] addr_sum;
    logic [spm_pkg::OVS_W-1:0] n;

    logic            div_start;
    logic [DW-1:0]   div_dividend;
    logic [spm_pkg::LEN_W-1:0] div_divisor;
    logic            div_done;
    logic [DW-1:0]   div_quo;
    logic [spm_pkg::LEN_W-1:0] div_rem;

    logic signed [spm_pkg::ACC_W-1:0] acc_sel;
    logic [spm_pkg::ACC_W-1:0]        acc_mag;
    logic                             res_neg;
    logic [spm_pkg::OUT_W-1:0]        res_sat;
    logic signed [spm_pkg::PROD_W-1:0] prod_full;

    assign c    = cmd.ch;
    assign ptr  = ptr_reg[c];
    assign intp = ptr[PW-1:FRAC_BITS];
    assign lenx = PW'({len_reg[c], {FRAC_BITS{1'b0}}});
    assign n    = (ovs_reg == '0) ? spm_pkg::OVS_W'(1) : ovs_reg;

    // Classify the current channel's sub-step.
    always_comb
    begin
        ev   = spm_pkg::EV_ZERO;
        base = start_reg[c];
        unique case (mode_reg[c])
            spm_pkg::MODE_PLAY:
            begin
                if (ptr < lenx)
                    ev = spm_pkg::EV_READ;
                else
                    ev = spm_pkg::EV_AGAIN;
            end
            spm_pkg::MODE_LOOP:
            begin
                base = lstart_reg[c];
                if (llen_reg[c] == '0)
                    ev = spm_pkg::EV_ZERO;
                else if (intp >= IW'(llen_reg[c]))
                    ev = spm_pkg::EV_DIV;
                else
                    ev = spm_pkg::EV_READ;
            end
            default: ev = spm_pkg::EV_ZERO;
        endcase
        addr_sum = base + intp[spm_pkg::LEN_W-1:0];
        rd_addr  = addr_sum[ADDR_W-1:0];
    end

    // Shared divider: pointer wrap or final scaling.
    always_comb
    begin
        acc_sel      = cmd.div_r_start ? accr_reg : accl_reg;
        div_start    = (cmd.eval && ev == spm_pkg::EV_DIV) || cmd.div_l_start || cmd.div_r_start;
        div_dividend = DW'(intp);
        div_divisor  = llen_reg[c];
        if (cmd.div_l_start || cmd.div_r_start)
        begin
            div_dividend = DW'(acc_sel[spm_pkg::ACC_W-1] ? -acc_sel : acc_sel);
            div_divisor  = spm_pkg::LEN_W'(n);
        end
    end

    spm_div #(.DW(DW), .VW(spm_pkg::LEN_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sign restore and saturation of the scaled sum, and the volume product of the read byte.
    always_comb
    begin
        acc_mag = spm_pkg::ACC_W'(div_quo);
        res_neg = cmd.store_r ? accr_reg[spm_pkg::ACC_W-1] : accl_reg[spm_pkg::ACC_W-1];
        if (res_neg)
            res_sat = (acc_mag > spm_pkg::ACC_W'(16384)) ? spm_pkg::OUT_W'(16384)
                                                         : spm_pkg::OUT_W'(-acc_mag);
        else
            res_sat = (acc_mag > spm_pkg::ACC_W'(16383)) ? spm_pkg::OUT_W'(16383)
                                                         : acc_mag[spm_pkg::OUT_W-1:0];
        prod_full = $signed(rdata_reg) * $signed({1'b0, vol_reg[c]});
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && in_op == spm_pkg::OP_WRITE)
            mem[in_address[ADDR_W-1:0]] <= in_sample_byte;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH; i++)
            begin
                mode_reg[i]   <= spm_pkg::MODE_SILENT;
                ptr_reg[i]    <= '0;
                step_reg[i]   <= '0;
                vol_reg[i]    <= '0;
                start_reg[i]  <= '0;
                len_reg[i]    <= '0;
                lstart_reg[i] <= '0;
                llen_reg[i]   <= '0;
            end
            ovs_reg <= spm_pkg::OVS_W'(1);
        end
        else
        begin
            if (cfg_wen)
                ovs_reg <= cfg_wdata;
            if (in_accept)
            begin
                case (in_op)
                    spm_pkg::OP_NOTE:
                    begin
                        start_reg[in_channel]  <= in_address;
                        len_reg[in_channel]    <= in_oneshot_length;
                        lstart_reg[in_channel] <= in_loop_start;
                        llen_reg[in_channel]   <= in_loop_length;
                        step_reg[in_channel]   <= in_step_increment;
                        ptr_reg[in_channel]    <= '0;
                        mode_reg[in_channel]   <= spm_pkg::MODE_PLAY;
                    end
                    spm_pkg::OP_STEP:   step_reg[in_channel] <= in_step_increment;
                    spm_pkg::OP_VOLUME: vol_reg[in_channel]  <= in_volume;
                    spm_pkg::OP_POSITION:
                        ptr_reg[in_channel] <= PW'({in_position, {FRAC_BITS{1'b0}}});
                    default: ;
                endcase
            end
            if (cmd.eval)
            begin
                if (mode_reg[c] == spm_pkg::MODE_PLAY && ev == spm_pkg::EV_AGAIN)
                begin
                    mode_reg[c] <= spm_pkg::MODE_LOOP;
                    ptr_reg[c]  <= ptr - lenx;
                end
                else if (mode_reg[c] == spm_pkg::MODE_LOOP && llen_reg[c] == '0)
                    mode_reg[c] <= spm_pkg::MODE_SILENT;
            end
            if (cmd.mac)
                ptr_reg[c] <= ptr + PW'(step_reg[c]);
            if (cmd.ptr_wb)
                ptr_reg[c] <= {IW'(div_rem), ptr[FRAC_BITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac)
            prod_reg <= prod_full;
        if (cmd.clr_acc)
        begin
            accl_reg <= '0;
            accr_reg <= '0;
        end
        else if (cmd.acc)
        begin
            if (c == 2'd0 || c == 2'd3)
                accl_reg <= accl_reg + spm_pkg::ACC_W'(prod_reg);
            else
                accr_reg <= accr_reg + spm_pkg::ACC_W'(prod_reg);
        end
        // Scaled sums wait here so that a stalled result keeps its data.
        if (cmd.store_l)
            lres_reg <= res_sat;
        if (cmd.store_r)
            rres_reg <= res_sat;
        if (cmd.out_load)
        begin
            left_reg  <= lres_reg;
            right_reg <= rres_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.ev       = ev;
    assign status.div_done = div_done;
    assign status.out_full = out_valid_reg && !out_ready;
    assign status.n        = n;

    assign out_valid = out_valid_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;

endmodule

// ===== rtl/spm_ctrl.sv =====
// Controller state machine sequencing channels, sub-steps and final scaling.
module spm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  spm_pkg::op_t     in_op,
    output logic             in_ready,
    output logic             in_accept,
    output spm_pkg::cmd_t    cmd,
    input  spm_pkg::status_t status
);

    spm_pkg::state_t state_reg, state_next;
    logic [1:0]                ch_reg, ch_next;
    logic [spm_pkg::OVS_W-1:0] sub_reg, sub_next;
    spm_pkg::state_t           adv_state;
    logic [1:0]                adv_ch;
    logic [spm_pkg::OVS_W-1:0] adv_sub;

    assign in_ready  = (state_reg == spm_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // Move to the next sub-step, channel, or to scaling.
    always_comb
    begin
        adv_state = spm_pkg::ST_EVAL;
        adv_ch    = ch_reg;
        adv_sub   = sub_reg + 1'b1;
        if (adv_sub == status.n)
        begin
            adv_sub = '0;
            if (ch_reg == 2'(spm_pkg::CHANNELS - 1))
                adv_state = spm_pkg::ST_DIVL_GO;
            else
                adv_ch = ch_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        sub_next   = sub_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        unique case (state_reg)
            spm_pkg::ST_IDLE:
            begin
                if (in_accept && in_op == spm_pkg::OP_TICK)
                begin
                    cmd.clr_acc = 1'b1;
                    ch_next     = '0;
                    sub_next    = '0;
                    state_next  = spm_pkg::ST_EVAL;
                end
            end
            spm_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                unique case (status.ev)
                    spm_pkg::EV_READ:  state_next = spm_pkg::ST_MAC;
                    spm_pkg::EV_AGAIN: state_next = spm_pkg::ST_EVAL;
                    spm_pkg::EV_DIV:   state_next = spm_pkg::ST_DIVP;
                    default:
                    begin
                        state_next = adv_state;
                        ch_next    = adv_ch;
                        sub_next   = adv_sub;
                    end
                endcase
            end
            spm_pkg::ST_MAC:
            begin
                cmd.mac    = 1'b1;
                state_next = spm_pkg::ST_ACC;
            end
            spm_pkg::ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = adv_state;
                ch_next    = adv_ch;
                sub_next   = adv_sub;
            end
            spm_pkg::ST_DIVP:
            begin
                if (status.div_done)
                begin
                    cmd.ptr_wb = 1'b1;
                    state_next = spm_pkg::ST_EVAL;
                end
            end
            spm_pkg::ST_DIVL_GO:
            begin
                cmd.div_l_start = 1'b1;
                state_next      = spm_pkg::ST_DIVL;
            end
            spm_pkg::ST_DIVL:
            begin
                if (status.div_done)
                begin
                    cmd.store_l     = 1'b1;
                    cmd.div_r_start = 1'b1;
                    state_next      = spm_pkg::ST_DIVR;
                end
            end
            spm_pkg::ST_DIVR:
            begin
                if (status.div_done)
                begin
                    cmd.store_r = 1'b1;
                    state_next  = spm_pkg::ST_OUT;
                end
            end
            spm_pkg::ST_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = spm_pkg::ST_IDLE;
                end
            end
            default: state_next = spm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spm_pkg::ST_IDLE;
            ch_reg    <= '0;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            sub_reg   <= sub_next;
        end
    end

endmodule

// ===== rtl/sample_playback_mixer_core.sv =====
// Top level of the four-channel sample playback mixer.
//
//   channel   direction  contents
//   s_axis    in         tuser: operation; tdata: command fields
//   m_axis    out        tdata: left_sample, right_sample
//   cfg       in         oversample register write
//
// Non-tick transactions are taken in the idle state. A tick passes, per channel
// and sub-step, through the evaluate state for a silent channel, through evaluate,
// multiply and accumulate for a played byte, through one more evaluate for a
// one-shot-to-loop change and through a wait on the shared divider when the loop
// pointer must be wrapped; then two divisions scale the sums, framed by a start
// state and an output state. Reset clears all channel state and sets oversample
// to 1; sample memory is not cleared. A stalled result waits in the output
// register while non-tick transactions are still taken; a new tick finishes
// only once the output slot is free.
module sample_playback_mixer_core #(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tuser: operation[2:0]
    input  logic [2:0]                        s_axis_tuser,
    // tdata: channel[1:0], address[17:2], sample_byte[25:18],
    // oneshot_length[41:26], loop_start[57:42], loop_length[73:58],
    // step_increment[93:74], volume[100:94], position[116:101], zero pad
    input  logic [spm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: left_sample[14:0], right_sample[29:15], zero pad
    output logic [spm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_wen,
    input  logic [spm_pkg::OVS_W-1:0]         cfg_wdata
);

    spm_pkg::cmd_t    cmd;
    spm_pkg::status_t status;
    spm_pkg::op_t     in_op;
    logic             in_accept;
    logic [spm_pkg::OUT_W-1:0] out_left, out_right;

    assign in_op = spm_pkg::op_t'(s_axis_tuser);

    spm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (in_op),
        .in_ready  (s_axis_tready),
        .in_accept (in_accept),
        .cmd       (cmd),
        .status    (status)
    );

    spm_dp #(.FRAC_BITS(FRAC_BITS), .SAMPLE_DEPTH(SAMPLE_DEPTH)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_accept         (in_accept),
        .in_op             (in_op),
        .in_channel        (s_axis_tdata[1:0]),
        .in_address        (s_axis_tdata[17:2]),
        .in_sample_byte    (s_axis_tdata[25:18]),
        .in_oneshot_length (s_axis_tdata[41:26]),
        .in_loop_start     (s_axis_tdata[57:42]),
        .in_loop_length    (s_axis_tdata[73:58]),
        .in_step_increment (s_axis_tdata[93:74]),
        .in_volume         (s_axis_tdata[100:94]),
        .in_position       (s_axis_tdata[116:101]),
        .cfg_wen           (cfg_wen),
        .cfg_wdata         (cfg_wdata),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_left          (out_left),
        .out_right         (out_right)
    );

    // Left in the low half, right above it, zero padding on top.
    assign m_axis_tdata = {2'b00, out_right, out_left};

endmodule

// ===== rtl/spm_checker.sv =====
// Port-level checker for the sample playback mixer, bound to the top level.
`include "sample_playback_mixer_core_assert.svh"

module spm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [2:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [spm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic tick_offer;
    logic tick_accept;

    assign tick_offer  = s_axis_tvalid && (s_axis_tuser == spm_pkg::OP_TICK);
    assign tick_accept = tick_offer && s_axis_tready;

    `SPM_ASSERT(a_tick_busy, tick_accept |=> !s_axis_tready, "input must stall after a tick")
    `SPM_ASSERT(a_busy_only_tick, $fell(s_axis_tready) |-> $past(tick_offer), "stall without tick")
    `SPM_ASSERT_HOLD(a_valid_hold, m_axis_tvalid, "result valid dropped while stalled")
    `SPM_ASSERT_HOLD(a_data_hold, m_axis_tdata, "result data changed while stalled")

endmodule

bind sample_playback_mixer_core spm_checker u_spm_checker (.*);

// ===== test/spm_mixer_checker.sv =====
// Checker for the sample playback mixer: it predicts each stereo frame and compares it.
module spm_mixer_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [2:0]                     s_axis_tuser,
    input  logic [spm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [spm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_wen,
    input  logic [spm_pkg::OVS_W-1:0]      cfg_wdata,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int CHN  = spm_pkg::CHANNELS;
    localparam int PW   = spm_pkg::PTR_W;
    localparam int LW   = spm_pkg::LEN_W;
    localparam int OW   = spm_pkg::OUT_W;

    typedef struct packed {
        logic signed [OW-1:0] left;
        logic signed [OW-1:0] right;
    } frame_t;

    logic signed [7:0]           mem [0:65535];
    spm_pkg::mode_t              mode [CHN];
    logic [PW-1:0]               ptr [CHN];
    logic [spm_pkg::STEP_W-1:0]  step [CHN];
    logic [spm_pkg::VOL_W-1:0]   vol [CHN];
    logic [LW-1:0]               start [CHN];
    logic [LW-1:0]               len [CHN];
    logic [LW-1:0]               lstart [CHN];
    logic [LW-1:0]               llen [CHN];
    logic [spm_pkg::OVS_W-1:0]   ovs;
    frame_t                      frames_due [$];

    function automatic int fetch(logic [LW-1:0] base, logic [PW-1:0] p);
        logic [LW-1:0] a;
        a = base + LW'(p >> FRAC);
        return int'(mem[a]);
    endfunction

    // One sub-step of one channel, returning its contribution to the sum.
    function automatic int advance(int c);
        logic [PW-1:0] lim;
        int v;
        if (mode[c] == spm_pkg::MODE_PLAY) begin
            lim = PW'(len[c]) << FRAC;
            if (ptr[c] < lim) begin
                v = fetch(start[c], ptr[c]) * int'(vol[c]);
                ptr[c] = ptr[c] + PW'(step[c]);
                return v;
            end
            mode[c] = spm_pkg::MODE_LOOP;
            ptr[c] = ptr[c] - lim;
        end
        if (mode[c] == spm_pkg::MODE_LOOP) begin
            if (llen[c] == 0) begin
                mode[c] = spm_pkg::MODE_SILENT;
                return 0;
            end
            ptr[c] = ptr[c] % (PW'(llen[c]) << FRAC);
            v = fetch(lstart[c], ptr[c]) * int'(vol[c]);
            ptr[c] = ptr[c] + PW'(step[c]);
            return v;
        end
        return 0;
    endfunction

    function automatic logic signed [OW-1:0] scale(int sum, int n);
        int q;
        q = sum / n;
        if (q > 16383) q = 16383;
        if (q < -16384) q = -16384;
        return OW'(q);
    endfunction

    function automatic frame_t mix_frame();
        int acc [CHN];
        int n;
        frame_t f;
        n = (ovs == 0) ? 1 : int'(ovs);
        for (int c = 0; c < CHN; c++) begin
            acc[c] = 0;
            for (int s = 0; s < n; s++)
                acc[c] += advance(c);
        end
        f.left  = scale(acc[0] + acc[3], n);
        f.right = scale(acc[1] + acc[2], n);
        return f;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [1:0] ch;
        frame_t f;
        frame_t got;
        if (!rst_n) begin
            for (int c = 0; c < CHN; c++) begin
                mode[c] = spm_pkg::MODE_SILENT;
                ptr[c] = '0;
                step[c] = '0;
                vol[c] = '0;
                start[c] = '0;
                len[c] = '0;
                lstart[c] = '0;
                llen[c] = '0;
            end
            ovs = 1;
            frames_due.delete();
            errors = 0;
        end
        else begin
            if (cfg_wen)
                ovs = cfg_wdata;
            // The output side is checked first; a frame in flight is always older.
            if (m_axis_tvalid && m_axis_tready) begin
                got = frame_t'({m_axis_tdata[14:0], m_axis_tdata[29:15]});
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame left=%0d right=%0d", $time,
                             got.left, got.right);
                    errors++;
                end
                else begin
                    f = frames_due.pop_front();
                    if (got.left !== f.left) begin
                        $display("%0t: left expected %0d actual %0d", $time, f.left, got.left);
                        errors++;
                    end
                    if (got.right !== f.right) begin
                        $display("%0t: right expected %0d actual %0d", $time,
                                 f.right, got.right);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                ch = s_axis_tdata[1:0];
                case (s_axis_tuser)
                    spm_pkg::OP_TICK:     frames_due.push_back(mix_frame());
                    spm_pkg::OP_WRITE:    mem[s_axis_tdata[17:2]] = s_axis_tdata[25:18];
                    spm_pkg::OP_NOTE:
                    begin
                        start[ch]  = s_axis_tdata[17:2];
                        len[ch]    = s_axis_tdata[41:26];
                        lstart[ch] = s_axis_tdata[57:42];
                        llen[ch]   = s_axis_tdata[73:58];
                        step[ch]   = s_axis_tdata[93:74];
                        ptr[ch]    = '0;
                        mode[ch]   = spm_pkg::MODE_PLAY;
                    end
                    spm_pkg::OP_STEP:     step[ch] = s_axis_tdata[93:74];
                    spm_pkg::OP_VOLUME:   vol[ch] = s_axis_tdata[100:94];
                    spm_pkg::OP_POSITION: ptr[ch] = PW'(s_axis_tdata[116:101]) << FRAC;
                    default:     ;
                endcase
            end
        end
        pending = frames_due.size();
    end
endmodule

// ===== test/tb_sample_playback_mixer_core.sv =====
// Testbench top of the sample playback mixer: stimulus, receiver stalls and verdict.
module tb_sample_playback_mixer_core;
    timeunit 1ns;
    timeprecision 1ps;

    // A run stops when this many cycles pass with no transaction on either side.
    localparam int IDLE_LIMIT = 40000;
    // Settle time after the last frame, longer than the slowest tick.
    localparam int SETTLE = 2000;
    localparam int PHASE_ITEMS = 290;
    // All reads stay in a 256-byte window that wraps across the top of memory.
    localparam logic [15:0] WIN_BASE = 16'hFF80;
    localparam int WIN_SIZE = 256;
    localparam int IDW = spm_pkg::IN_DATA_W;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [2:0]                     s_axis_tuser;
    logic [IDW-1:0]                 s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [spm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           cfg_wen;
    logic [spm_pkg::OVS_W-1:0]      cfg_wdata;
    int                             errors;
    int                             pending;
    int                             burst_left;
    int                             quiet_cycles;
    logic                           gaps_on;
    logic                           long_hold;

    sample_playback_mixer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    spm_mixer_checker frame_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Builds a full transaction word; every field gets random content so that all
    // bits toggle, and the caller overrides the fields that matter for the test.
    function automatic logic [IDW-1:0] rand_word();
        logic [127:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        w[119:117] = '0;
        return w[IDW-1:0];
    endfunction

    function automatic logic [IDW-1:0] pack_fields(
        logic [1:0] ch, logic [15:0] addr, logic [7:0] sbyte, logic [15:0] olen,
        logic [15:0] lstart, logic [15:0] llen, logic [19:0] stp, logic [6:0] vol,
        logic [15:0] pos);
        return {3'b000, pos, vol, stp, llen, lstart, olen, sbyte, addr, ch};
    endfunction

    // Offers one transaction and returns once it has been accepted. The valid
    // stays high into the next transaction unless a gap between bursts is due.
    task automatic send(logic [2:0] op, logic [IDW-1:0] data);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Register writes only happen while the block has nothing left to do.
    task automatic set_oversample(logic [spm_pkg::OVS_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic directed_items();
        send(spm_pkg::OP_VOLUME, pack_fields(2'd0, 0, 0, 0, 0, 0, 0, 7'd64, 0));
        send(spm_pkg::OP_VOLUME, pack_fields(2'd3, 0, 0, 0, 0, 0, 0, 7'd127, 0));
        send(spm_pkg::OP_VOLUME, pack_fields(2'd1, 0, 0, 0, 0, 0, 0, 7'd0, 0));
        send(spm_pkg::OP_VOLUME, pack_fields(2'd2, 0, 0, 0, 0, 0, 0, 7'd33, 0));
        // A silent channel stays silent after a position change.
        send(spm_pkg::OP_POSITION, pack_fields(2'd2, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        send(spm_pkg::OP_TICK, '0);
        // Start at the top of memory so that the address wraps; no loop follows.
        send(spm_pkg::OP_NOTE, pack_fields(2'd0, 16'hFFFF, 0, 16'd3, 0, 16'd0, 20'h10000,
                                           0, 0));
        // Largest step, with a loop below the top of memory.
        send(spm_pkg::OP_NOTE, pack_fields(2'd1, 16'h0000, 0, 16'h0080, 16'hFF80, 16'h0080,
                                           20'hFFFFF, 0, 0));
        // Empty one-shot part goes straight into a one-byte loop.
        send(spm_pkg::OP_NOTE, pack_fields(2'd2, 16'h0010, 0, 16'd0, 16'h0000, 16'd1,
                                           20'h08000, 0, 0));
        // A zero step holds the pointer on the most negative byte.
        send(spm_pkg::OP_NOTE, pack_fields(2'd3, 16'h0000, 0, 16'd5, 16'h0020, 16'd7,
                                           20'h0, 0, 0));
        send(spm_pkg::OP_TICK, '0);
        send(spm_pkg::OP_TICK, '0);
        send(spm_pkg::OP_STEP, pack_fields(2'd3, 0, 0, 0, 0, 0, 20'h30000, 0, 0));
        send(spm_pkg::OP_POSITION, pack_fields(2'd3, 0, 0, 0, 0, 0, 0, 0, 16'd4));
        send(spm_pkg::OP_TICK, '0);
        send(3'd6, rand_word());
        send(3'd7, rand_word());
        repeat (4) send(spm_pkg::OP_TICK, '0);
        send(spm_pkg::OP_POSITION, pack_fields(2'd1, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        send(spm_pkg::OP_TICK, '0);
    endtask

    task automatic random_items(int count);
        logic [IDW-1:0] w;
        logic [2:0] op;
        int pick;
        for (int i = 0; i < count; i++) begin
            w = rand_word();
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = spm_pkg::OP_TICK;
            else if (pick < 50) op = spm_pkg::OP_NOTE;
            else if (pick < 60) op = spm_pkg::OP_STEP;
            else if (pick < 72) op = spm_pkg::OP_VOLUME;
            else if (pick < 80) op = spm_pkg::OP_POSITION;
            else if (pick < 95) op = spm_pkg::OP_WRITE;
            else                op = 3'($urandom_range(6, 7));
            // Notes start in the written window and their regions stay inside it.
            if (op == spm_pkg::OP_NOTE) begin
                w[17:2]  = WIN_BASE + 16'($urandom_range(0, 127));
                w[57:42] = WIN_BASE + 16'($urandom_range(0, 127));
                w[41:26] = 16'($urandom_range(0, 128));
                w[73:58] = 16'($urandom_range(0, 128));
            end
            // Mostly short regions and pitch-like steps, so notes reach their loops.
            if ($urandom_range(0, 3) != 0) begin
                w[41:26] = 16'($urandom_range(0, 40));
                w[73:58] = 16'($urandom_range(0, 24));
                w[93:74] = 20'($urandom_range(0, 20'h30000));
                w[116:101] = 16'($urandom_range(0, 48));
            end
            if ($urandom_range(0, 3) != 0)
                w[100:94] = 7'($urandom_range(0, 64));
            send(op, w);
        end
    endtask

    // Receiver: ready pattern whose character (always, half or a quarter of the time) is
    // drawn at random, plus one long hold-off that lets the output fill and the input back up.
    initial
    begin
        int mode_sel;
        int hold;
        m_axis_tready <= 1'b0;
        forever
        begin
            mode_sel = $urandom_range(0, 2);
            for (int k = 0; k < 64; k++) begin
                @(posedge clk);
                if (long_hold) begin
                    m_axis_tready <= 1'b0;
                    for (hold = 0; hold < 600; hold++)
                        @(posedge clk);
                    long_hold = 1'b0;
                end
                case (mode_sel)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tb_sample_playback_mixer_core failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [spm_pkg::OVS_W-1:0] ovs_list [6];
        ovs_list = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd2, 4'd1};
        ovs_list[5] = 4'($urandom_range(3, 7));
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= '0;
        s_axis_tdata  <= '0;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= '0;
        gaps_on = 1'b0;
        long_hold = 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the read window first, so that no read ever hits an unwritten
        // byte; the extremes of address and value are written explicitly.
        for (int a = 0; a < WIN_SIZE; a++)
            send(spm_pkg::OP_WRITE, pack_fields(2'($urandom), WIN_BASE + 16'(a),
                                                8'($urandom), 0, 0, 0, 0, 0, 0));
        send(spm_pkg::OP_WRITE, pack_fields(0, 16'h0000, 8'h80, 0, 0, 0, 0, 0, 0));
        send(spm_pkg::OP_WRITE, pack_fields(0, 16'hFFFF, 8'h7F, 0, 0, 0, 0, 0, 0));
        gaps_on = 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            set_oversample(ovs_list[ph]);
            if (ph == 0)
                directed_items();
            if (ph == 1)
                long_hold = 1'b1;
            random_items(PHASE_ITEMS);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("tb_sample_playback_mixer_core passed");
        else
            $display("tb_sample_playback_mixer_core failed");
        $finish;
    end
endmodule
